### rtl/core/gkm_pkg.sv
`timescale 1ns / 1ps

package gkm_pkg;

    localparam int MAX_OPERAND_WORDS_DEF = 2048;
    localparam int WORD_BITS     = 64;
    localparam int INDEX_BITS    = 12;
    localparam int CFG_BITS      = 4;
    localparam int CELL_COUNT    = 8;
    localparam int BITS_PER_CELL = WORD_BITS / CELL_COUNT;
    localparam logic [CFG_BITS-1:0] LOG2_MIN = 4'd4;
    localparam logic [CFG_BITS-1:0] LOG2_MAX = 4'd11;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic                  command;
        logic [INDEX_BITS-1:0] word_index;
        logic [WORD_BITS-1:0]  a_word;
        logic [WORD_BITS-1:0]  b_word;
    } cmd_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] product_word;
        logic                 index_out_of_range;
    } rsp_t;

    // Sideband that rides with each word pair through the multiplier chain.
    typedef struct packed {
        logic                  first;
        logic                  last;
        logic                  final_word;
        logic [INDEX_BITS:0]   kidx;
    } tag_t;

    typedef struct packed {
        tag_t                   tag;
        logic [2*WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0]   b;
        logic [2*WORD_BITS-1:0] p;
    } cell_bus_t;

endpackage

### rtl/core/gkm_cell.sv
`timescale 1ns / 1ps

module gkm_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    input  gkm_pkg::cell_bus_t  bus_in,
    output logic                valid_out,
    output gkm_pkg::cell_bus_t  bus_out
);
    import gkm_pkg::*;

    logic      valid_reg;
    cell_bus_t bus_reg;
    cell_bus_t bus_next;

    // Each cell folds in the low slice of b, then hands the shifted operands on.
    always_comb
    begin
        bus_next     = bus_in;
        bus_next.a   = bus_in.a << BITS_PER_CELL;
        bus_next.b   = bus_in.b >> BITS_PER_CELL;
        for (int t = 0; t < BITS_PER_CELL; t++)
        begin
            if (bus_in.b[t])
            begin
                bus_next.p = bus_next.p ^ (bus_in.a << t);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        bus_reg <= bus_next;
    end

    assign valid_out = valid_reg;
    assign bus_out   = bus_reg;

endmodule

### rtl/core/gkm_cell_row.sv
`timescale 1ns / 1ps

module gkm_cell_row (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    input  gkm_pkg::cell_bus_t  bus_in,
    output logic                valid_out,
    output gkm_pkg::cell_bus_t  bus_out
);
    import gkm_pkg::*;

    logic      valid_link [CELL_COUNT+1];
    cell_bus_t bus_link   [CELL_COUNT+1];

    assign valid_link[0] = valid_in;
    assign bus_link[0]   = bus_in;

    for (genvar c = 0; c < CELL_COUNT; c++)
    begin : g_cell
        gkm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_link[c]),
            .bus_in    (bus_link[c]),
            .valid_out (valid_link[c+1]),
            .bus_out   (bus_link[c+1])
        );
    end

    assign valid_out = valid_link[CELL_COUNT];
    assign bus_out   = bus_link[CELL_COUNT];

endmodule

### rtl/core/gf2_poly_karatsuba_multiplier.sv
`timescale 1ns / 1ps

// Carry-less GF(2) multiplier for two polynomials of N 64-bit words (N = 2^cfg_wdata, 16..2048).
// A load beat writes one A/B word pair; loading word N-1 starts the product, and the command
// channel stalls while one word pair per cycle streams from the operand memories through a
// chain of eight cells, each folding in eight bits of B, into an accumulator that writes each
// finished product word. A read beat is registered in rd_pend_reg and then in the response
// register; a further read is taken once that response has been taken.
module gf2_poly_karatsuba_multiplier #(
    parameter int MAX_OPERAND_WORDS = gkm_pkg::MAX_OPERAND_WORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gkm_pkg::CFG_BITS-1:0]  cfg_wdata,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  gkm_pkg::cmd_t                 cmd,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output gkm_pkg::rsp_t                 rsp
);
    import gkm_pkg::*;

    localparam int AW    = $clog2(MAX_OPERAND_WORDS);
    localparam int PAW   = $clog2(2 * MAX_OPERAND_WORDS);
    localparam int CW    = PAW + 1;
    localparam int LGMAX = $clog2(MAX_OPERAND_WORDS + 1) - 1;
    localparam int XW    = INDEX_BITS + 1;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

    logic [CFG_BITS-1:0] cfg_reg;
    logic [CFG_BITS-1:0] lg;
    logic [CW-1:0]       n_words;
    logic [CW-1:0]       two_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= LOG2_MIN;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        lg = cfg_reg;
        priority if (cfg_reg < LOG2_MIN)
        begin
            lg = LOG2_MIN;
        end
        else if (cfg_reg > LOG2_MAX)
        begin
            lg = LOG2_MAX;
        end
        else
        begin
            lg = cfg_reg;
        end
        if (lg > CFG_BITS'(LGMAX))
        begin
            lg = CFG_BITS'(LGMAX);
        end
    end

    assign n_words = CW'(1) << lg;
    assign two_n   = n_words << 1;

    // Command acceptance.
    state_t state_reg;
    logic   rd_pend_reg;
    logic   oor_reg;
    logic   rsp_valid_reg;
    rsp_t   rsp_reg;
    logic   cmd_accept;
    logic   load_ok;
    logic   start;
    logic   read_accept;
    logic   read_oor;

    assign cmd_stall = (state_reg != ST_IDLE) || rd_pend_reg
                       || (rsp_valid_reg && cmd.command == CMD_READ);
    assign cmd_accept  = cmd_valid && !cmd_stall;
    assign load_ok     = cmd_accept && cmd.command == CMD_LOAD
                         && ({1'b0, cmd.word_index} < XW'(n_words));
    assign start       = load_ok && ({1'b0, cmd.word_index} == XW'(n_words - CW'(1)));
    assign read_accept = cmd_accept && cmd.command == CMD_READ;
    assign read_oor    = !({1'b0, cmd.word_index} < XW'(two_n));

    // Product sequencer: walks output words k and the pairs i + j = k.
    logic [CW-1:0] k_reg;
    logic [CW-1:0] i_reg;
    logic          first_reg;
    logic [CW-1:0] hi_i;
    logic [CW-1:0] lo_next;
    logic [CW-1:0] j_idx;
    logic          is_final;
    logic          is_last;
    logic          wb_final;

    assign hi_i     = (k_reg < n_words) ? k_reg : (n_words - CW'(1));
    assign lo_next  = (k_reg >= n_words - CW'(1)) ? (k_reg + CW'(2) - n_words) : '0;
    assign j_idx    = k_reg - i_reg;
    assign is_final = (k_reg == two_n - CW'(1));
    assign is_last  = is_final || (i_reg == hi_i);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            i_reg     <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_RUN;
                        k_reg     <= '0;
                        i_reg     <= '0;
                        first_reg <= 1'b1;
                    end
                end
                ST_RUN:
                begin
                    if (is_last)
                    begin
                        first_reg <= 1'b1;
                        k_reg     <= k_reg + CW'(1);
                        i_reg     <= lo_next;
                        if (is_final)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                    else
                    begin
                        first_reg <= 1'b0;
                        i_reg     <= i_reg + CW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (wb_final)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Operand memories.
    logic [WORD_BITS-1:0] a_mem [MAX_OPERAND_WORDS];
    logic [WORD_BITS-1:0] b_mem [MAX_OPERAND_WORDS];
    logic [WORD_BITS-1:0] rd_a_reg;
    logic [WORD_BITS-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            a_mem[cmd.word_index[AW-1:0]] <= cmd.a_word;
            b_mem[cmd.word_index[AW-1:0]] <= cmd.b_word;
        end
        rd_a_reg <= a_mem[i_reg[AW-1:0]];
        rd_b_reg <= b_mem[j_idx[AW-1:0]];
    end

    logic s1_valid_reg;
    tag_t s1_tag_reg;
    tag_t issue_tag;

    always_comb
    begin
        issue_tag.first      = first_reg;
        issue_tag.last       = is_last;
        issue_tag.final_word = is_final;
        issue_tag.kidx       = (INDEX_BITS + 1)'(k_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= (state_reg == ST_RUN);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg <= issue_tag;
    end

    // The final beat carries no pair; it only flushes the top half of the last sum.
    cell_bus_t row_in;
    cell_bus_t row_out;
    logic      row_valid;

    always_comb
    begin
        row_in.tag = s1_tag_reg;
        row_in.a   = s1_tag_reg.final_word ? '0 : {{WORD_BITS{1'b0}}, rd_a_reg};
        row_in.b   = rd_b_reg;
        row_in.p   = '0;
    end

    gkm_cell_row u_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s1_valid_reg),
        .bus_in    (row_in),
        .valid_out (row_valid),
        .bus_out   (row_out)
    );

    // Accumulate the 128-bit sums; word k is the low half of sum k plus the high half of k-1.
    logic [2*WORD_BITS-1:0] acc_reg;
    logic [2*WORD_BITS-1:0] acc_next;
    logic [WORD_BITS-1:0]   prev_hi_reg;
    logic                   wb_en;
    logic [WORD_BITS-1:0]   wb_word;

    assign acc_next = row_out.tag.first ? row_out.p : (acc_reg ^ row_out.p);
    assign wb_en    = row_valid && row_out.tag.last;
    assign wb_word  = acc_next[WORD_BITS-1:0] ^ prev_hi_reg;
    assign wb_final = wb_en && row_out.tag.final_word;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prev_hi_reg <= '0;
        end
        else if (wb_en)
        begin
            prev_hi_reg <= acc_next[2*WORD_BITS-1:WORD_BITS];
        end
        if (row_valid)
        begin
            acc_reg <= acc_next;
        end
    end

    // Product memory.
    logic [WORD_BITS-1:0] p_mem [2 * MAX_OPERAND_WORDS];
    logic [WORD_BITS-1:0] rd_p_reg;

    always_ff @(posedge clk)
    begin
        if (wb_en)
        begin
            p_mem[row_out.tag.kidx[PAW-1:0]] <= wb_word;
        end
        rd_p_reg <= p_mem[cmd.word_index[PAW-1:0]];
    end

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= read_accept;
            priority if (rd_pend_reg)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            else
            begin
                rsp_valid_reg <= rsp_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (read_accept)
        begin
            oor_reg <= read_oor;
        end
        if (rd_pend_reg)
        begin
            rsp_reg.product_word       <= oor_reg ? '0 : rd_p_reg;
            rsp_reg.index_out_of_range <= oor_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    a_no_cmd_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> cmd_stall)
        else $error("command taken during product computation");

    a_rsp_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(rd_pend_reg))
        else $error("response without a read");

    a_oor_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.index_out_of_range) |-> (rsp.product_word == '0))
        else $error("out-of-range read returned nonzero word");

    a_no_issue_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> !s1_valid_reg)
        else $error("pair issued while idle");
`endif

endmodule
